// ----- rtl/core/score_list_statistics_unit_macros.svh -----
// Assertion macros used by the checker file of the score list statistics unit.
`ifndef SCORE_LIST_STATISTICS_UNIT_MACROS_SVH
`define SCORE_LIST_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define SLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define SLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sls_pkg.sv -----
// Package with the types, constants and state codes of the score list statistics unit.
package sls_pkg;

    // Field widths of the item and result beats.
    localparam int SCORE_W  = 16;
    localparam int COUNT_W  = 6;
    localparam int TOTAL_W  = 21;
    localparam int MEAN_W   = 24;
    localparam int MEDIAN_W = 17;

    // The mean carries this many fraction bits.
    localparam int FRAC_W   = 8;

    // The bit-serial divider works through one dividend bit per cycle.
    localparam int DIV_BITS = TOTAL_W + FRAC_W;

    // Default number of scores that the store holds.
    localparam int MAX_SCORES_DEF = 32;

    // One input beat.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               end_marker;
    } sls_item_t;

    // One result beat.
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [TOTAL_W-1:0]  total;
        logic [MEAN_W-1:0]   mean_q8;
        logic [MEDIAN_W-1:0] median_doubled;
        logic [SCORE_W-1:0]  minimum;
        logic [SCORE_W-1:0]  maximum;
        logic                empty_res;
    } sls_result_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_PREP,
        ST_FINISH,
        ST_WAIT_OUT
    } sls_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // insert the score of the accepted beat
        logic prep;      // set up the divider and the median readout
        logic shift;     // shift the sorted row one place toward cell 0
        logic div_step;  // run one divider iteration
        logic capture;   // load the result register and start a new list
    } sls_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_slot; // the next stored score fills the store
    } sls_stat_t;

endpackage

// ----- rtl/core/sls_ctrl.sv -----
// Controller state machine of the score list statistics unit.
module sls_ctrl #(
    parameter int MAX_SCORES = sls_pkg::MAX_SCORES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_end_marker,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  sls_pkg::sls_stat_t stat,
    output sls_pkg::sls_cmd_t  cmd
);
    import sls_pkg::*;

    // The finishing phase must cover the divider and the median readout.
    localparam int MED_STEPS  = MAX_SCORES / 2 + 1;
    localparam int FIN_CYCLES = (DIV_BITS > MED_STEPS) ? DIV_BITS : MED_STEPS;
    localparam int STEP_W     = $clog2(FIN_CYCLES);

    sls_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              result_valid_reg, result_valid_next;
    logic              out_free;

    assign item_ready   = (state_reg == ST_COLLECT);
    assign result_valid = result_valid_reg;
    assign out_free     = !result_valid_reg || result_ready;

    // State, step counter and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_COLLECT;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (item_valid)
                begin
                    cmd.load = !item_end_marker;
                    if (item_end_marker || stat.last_slot)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.shift    = 1'b1;
                cmd.div_step = (32'(step_reg) < DIV_BITS);
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(FIN_CYCLES - 1))
                begin
                    state_next = ST_WAIT_OUT;
                end
            end
            ST_WAIT_OUT:
            begin
                if (out_free)
                begin
                    cmd.capture       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule

// ----- rtl/core/sls_datapath.sv -----
// Datapath of the score list statistics unit: sorted cell row, running values,
// bit-serial divider and result register.
module sls_datapath #(
    parameter int MAX_SCORES = sls_pkg::MAX_SCORES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sls_pkg::SCORE_W-1:0]  item_score,
    input  sls_pkg::sls_cmd_t            cmd,
    output sls_pkg::sls_stat_t           stat,
    output sls_pkg::sls_result_t         result
);
    import sls_pkg::*;

    localparam int CNT_W = $clog2(MAX_SCORES + 1);

    // Running values of the current list.
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [SCORE_W-1:0] min_reg, min_next;
    logic [SCORE_W-1:0] max_reg, max_next;

    // Sorted row of cells, ascending from cell 0; cells at or above the count are unused.
    logic [SCORE_W-1:0]    cell_reg [MAX_SCORES];
    logic [MAX_SCORES-1:0] cell_le;

    // Divider: dividend shifts out at the top while quotient bits shift in below.
    logic [DIV_BITS-1:0] div_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W:0]      rem_sh;
    logic                rem_ge;

    // Median readout.
    logic [CNT_W-1:0]   med_left_reg;
    logic               med_done_reg;
    logic [SCORE_W-1:0] med_lo_reg, med_hi_reg;
    logic               odd_count;
    logic [MEDIAN_W-1:0] median_val;

    sls_result_t result_reg;
    logic        empty;

    assign stat.last_slot = (count_reg == CNT_W'(MAX_SCORES - 1));
    assign result         = result_reg;

    // Running count, sum, minimum and maximum; a capture starts a new list.
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (cmd.capture)
        begin
            count_next = '0;
            sum_next   = '0;
            min_next   = '1;
            max_next   = '0;
        end
        else if (cmd.load)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + TOTAL_W'(item_score);
            if (item_score < min_reg)
            begin
                min_next = item_score;
            end
            if (item_score > max_reg)
            begin
                max_next = item_score;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // Each cell keeps its value, takes the new score, or takes its lower neighbor,
    // so the row stays sorted; during finishing the row shifts toward cell 0.
    for (genvar g = 0; g < MAX_SCORES; g++)
    begin : g_cell
        logic [SCORE_W-1:0] ins_val;
        logic [SCORE_W-1:0] shift_val;

        assign cell_le[g] = (CNT_W'(g) < count_reg) && (cell_reg[g] <= item_score);

        if (g == 0)
        begin : g_first
            assign ins_val = item_score;
        end
        else
        begin : g_rest
            assign ins_val = cell_le[g-1] ? item_score : cell_reg[g-1];
        end

        if (g == MAX_SCORES - 1)
        begin : g_top
            assign shift_val = cell_reg[g];
        end
        else
        begin : g_below
            assign shift_val = cell_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                if (!cell_le[g])
                begin
                    cell_reg[g] <= ins_val;
                end
            end
            else if (cmd.shift)
            begin
                cell_reg[g] <= shift_val;
            end
        end
    end

    // One restoring divider iteration per step.
    assign rem_sh = {rem_reg, div_reg[DIV_BITS-1]};
    assign rem_ge = (rem_sh >= {1'b0, count_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            div_reg <= {sum_reg, {FRAC_W{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= {div_reg[DIV_BITS-2:0], rem_ge};
            if (rem_ge)
            begin
                rem_reg <= CNT_W'(rem_sh - {1'b0, count_reg});
            end
            else
            begin
                rem_reg <= CNT_W'(rem_sh);
            end
        end
    end

    // Median readout: cell 0 shows the sorted scores in order, one per shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med_left_reg <= '0;
            med_done_reg <= 1'b1;
        end
        else if (cmd.prep)
        begin
            med_left_reg <= count_reg >> 1;
            med_done_reg <= 1'b0;
        end
        else if (cmd.shift && !med_done_reg)
        begin
            if (med_left_reg == '0)
            begin
                med_done_reg <= 1'b1;
            end
            else
            begin
                med_left_reg <= med_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift && !med_done_reg)
        begin
            if (med_left_reg == '0)
            begin
                med_hi_reg <= cell_reg[0];
            end
            else if (med_left_reg == CNT_W'(1))
            begin
                med_lo_reg <= cell_reg[0];
            end
        end
    end

    assign odd_count  = count_reg[0];
    assign median_val = odd_count ? {med_hi_reg, 1'b0}
                                  : MEDIAN_W'(med_lo_reg) + MEDIAN_W'(med_hi_reg);
    assign empty      = (count_reg == '0);

    // Result register, loaded once per finished list.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            result_reg.count          <= COUNT_W'(count_reg);
            result_reg.total          <= empty ? '0 : sum_reg;
            result_reg.mean_q8        <= empty ? '0 : MEAN_W'(div_reg);
            result_reg.median_doubled <= empty ? '0 : median_val;
            result_reg.minimum        <= empty ? '0 : min_reg;
            result_reg.maximum        <= empty ? '0 : max_reg;
            result_reg.empty_res      <= empty;
        end
    end

endmodule

// ----- rtl/core/score_list_statistics_unit.sv -----
// Top level of the score list statistics unit.
// The unit collects up to MAX_SCORES scores, one per cycle, keeping them in a
// sorted row of cells, and ends a list on an end-marker beat or on the beat
// that fills the store. It then gives one result beat with count, sum, mean
// (8 fraction bits, truncated), twice the median, minimum and maximum; an
// empty list gives zeros with empty_res set.
// Before the result register loads, the bit-serial divider for the mean
// resolves one of its 29 quotient bits per cycle while the sorted row shifts
// out the middle scores. During that time item_ready is low; the next list
// starts as soon as the result is loaded, and a finished list waits until
// the previous result beat is taken.
module score_list_statistics_unit #(
    parameter int MAX_SCORES = sls_pkg::MAX_SCORES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  sls_pkg::sls_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output sls_pkg::sls_result_t result
);
    import sls_pkg::*;

    sls_cmd_t  cmd;
    sls_stat_t stat;

    // Controller.
    sls_ctrl #(
        .MAX_SCORES(MAX_SCORES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_end_marker(item.end_marker),
        .item_ready     (item_ready),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Datapath.
    sls_datapath #(
        .MAX_SCORES(MAX_SCORES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_score(item.score),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// ----- rtl/core/sls_checker.sv -----
// Port-level assertion checker of the score list statistics unit and its bind.
`include "score_list_statistics_unit_macros.svh"

module sls_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input sls_pkg::sls_item_t   item,
    input logic                 result_valid,
    input logic                 result_ready,
    input sls_pkg::sls_result_t result
);
    import sls_pkg::*;

    // A result beat that is not taken stays up with the same payload.
    `SLS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result beat dropped or changed while stalled")

    // An end-marker beat starts the finishing phase, so no beat is taken next cycle.
    `SLS_ASSERT_NEXT(a_end_blocks_input, item_valid && item_ready && item.end_marker,
        !item_ready, "input taken right after an end marker")

    // An empty list reports all zeros.
    `SLS_ASSERT_SAME(a_empty_zero, result_valid && result.empty_res,
        result.count == '0 && result.total == '0 && result.mean_q8 == '0 &&
        result.median_doubled == '0 && result.minimum == '0 && result.maximum == '0,
        "empty list result not all zero")

    // A non-empty list has its median between its minimum and its maximum.
    `SLS_ASSERT_SAME(a_median_range, result_valid && !result.empty_res,
        result.minimum <= result.maximum &&
        result.median_doubled >= {1'b0, result.minimum} + {1'b0, result.minimum} &&
        result.median_doubled <= {1'b0, result.maximum} + {1'b0, result.maximum},
        "median outside the minimum to maximum range")

endmodule

bind score_list_statistics_unit sls_checker u_sls_checker (.*);
